@@ sv/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// Shared constants, command codes and drive helper for the I2C byte sequencer.
// ----------------------------------------------------------------------------
package i2cms_pkg;

	localparam int ACTION_W   = 3;
	localparam int BYTE_W     = 8;
	localparam int TICKS_W    = 16;
	localparam int STEP_W     = 3;
	localparam int BITCNT_W   = 4;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [TICKS_W-1:0] PHASE_TICKS_RST = TICKS_W'(1000);

	// command codes
	localparam logic [ACTION_W-1:0] CMD_IDLE  = ACTION_W'(0);
	localparam logic [ACTION_W-1:0] CMD_START = ACTION_W'(1);
	localparam logic [ACTION_W-1:0] CMD_STOP  = ACTION_W'(2);
	localparam logic [ACTION_W-1:0] CMD_WRITE = ACTION_W'(3);
	localparam logic [ACTION_W-1:0] CMD_READ  = ACTION_W'(4);

	// register index decoded from paddr[2]
	localparam logic REG_PHASE_TICKS = 1'b0;

	localparam logic [BITCNT_W-1:0] LAST_DATA_BIT = BITCNT_W'(7);
	localparam logic [BITCNT_W-1:0] BITS_PER_BYTE = BITCNT_W'(8);

	typedef struct packed {
		logic scl_low;
		logic sda_low;
	} drive_t;

	// Line drives for the phase selected by command, step and bit slot.
	function automatic drive_t phase_drive(
		input logic [ACTION_W-1:0] cmd,
		input logic [STEP_W-1:0]   step,
		input logic [BITCNT_W-1:0] bit_cnt,
		input logic [BYTE_W-1:0]   shift,
		input logic                ack_sel,
		input drive_t              hold
	);
		drive_t d;
		d = hold;
		case (cmd)
			CMD_START: begin
				d.scl_low = (step >= STEP_W'(2));
				d.sda_low = (step >= STEP_W'(1));
			end
			CMD_STOP: begin
				d.scl_low = (step == STEP_W'(0));
				d.sda_low = (step <= STEP_W'(1));
			end
			CMD_WRITE, CMD_READ: begin
				if (step >= STEP_W'(2)) begin
					d.scl_low = 1'b1;
					d.sda_low = 1'b0;
				end else begin
					d.scl_low = (step == STEP_W'(0));
					if (bit_cnt < BITS_PER_BYTE)
						d.sda_low = (cmd == CMD_WRITE) ? ~shift[BYTE_W-1] : 1'b0;
					else
						d.sda_low = (cmd == CMD_WRITE) ? 1'b0 : ack_sel;
				end
			end
			default: begin
				d = hold;
			end
		endcase
		return d;
	endfunction

endpackage

@@ sv/i2cms_if.sv @@
// ----------------------------------------------------------------------------
// i2cms channel interfaces
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface i2cms_req_if;
	import i2cms_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [BYTE_W-1:0]   data_byte;
	logic                master_ack;
	logic                sda_in;

	modport source (output valid, action, data_byte, master_ack, sda_in, input ready);
	modport sink   (input valid, action, data_byte, master_ack, sda_in, output ready);
endinterface

interface i2cms_rsp_if;
	import i2cms_pkg::*;

	logic              valid;
	logic              ready;
	logic              scl_drive_low;
	logic              sda_drive_low;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] read_data;
	logic              slave_ack;
	logic              rejected;

	modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res,
		read_data, slave_ack, rejected, input ready);
	modport sink   (input valid, scl_drive_low, sda_drive_low, busy_res, done_res,
		read_data, slave_ack, rejected, output ready);
endinterface

@@ sv/i2c_master_byte_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer
// Open-drain I2C master stepped by tick items: start, stop, write and read byte.
// ----------------------------------------------------------------------------
//
//  channel   dir   handshake            content
//  --------  ----  -------------------  ------------------------------------
//  req       in    valid/ready          action, data_byte, master_ack, sda_in
//  rsp       out   valid/ready          line drives, busy, done, read byte,
//                                       slave ack, rejected
//  apb       in    psel/penable/pready  phase_ticks at address 0
//
//  Each item is held in the input register, then the sequencer state and the
//  result register update together, so one item enters and one result leaves
//  per clock when rsp.ready stays high.
//  arst_n clears the sequencer to idle with both lines released and sets
//  phase_ticks to 1000. A stalled rsp holds its result; the input register
//  then fills and req.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer (
	input  logic                              clk,
	input  logic                              arst_n,
	i2cms_req_if.sink                         req,
	i2cms_rsp_if.source                       rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [i2cms_pkg::APB_ADDR_W-1:0]  paddr,
	input  logic [i2cms_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [i2cms_pkg::APB_DATA_W-1:0]  prdata,
	output logic                              pready
);
	import i2cms_pkg::*;

	// configuration
	logic [TICKS_W-1:0] phase_ticks_q;

	// input register
	logic                s1_valid_q;
	logic [ACTION_W-1:0] action_s1;
	logic [BYTE_W-1:0]   data_byte_s1;
	logic                master_ack_s1;
	logic                sda_in_s1;

	// sequencer state
	logic [TICKS_W-1:0]  phase_count_q;
	logic [STEP_W-1:0]   step_q;
	logic [BITCNT_W-1:0] bit_count_q;
	logic [ACTION_W-1:0] cmd_q;
	logic [BYTE_W-1:0]   shift_q;
	logic                ack_choice_q;
	drive_t              drive_q;
	logic                ack_result_q;
	logic [BYTE_W-1:0]   read_result_q;

	// result register
	logic                out_valid_q;
	logic                busy_q;
	logic                done_q;
	logic                rejected_q;

	// next-state values
	logic [TICKS_W-1:0]  n_phase_count;
	logic [STEP_W-1:0]   n_step;
	logic [BITCNT_W-1:0] n_bit_count;
	logic [ACTION_W-1:0] n_cmd;
	logic [BYTE_W-1:0]   n_shift;
	logic                n_ack_choice;
	drive_t              n_drive;
	logic                n_ack_result;
	logic [BYTE_W-1:0]   n_read_result;
	logic                n_done;
	logic                n_rejected;
	logic                set_drv;
	logic                phase_more;

	logic out_free;
	logic s1_go;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_PHASE_TICKS) ?
		APB_DATA_W'(phase_ticks_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == REG_PHASE_TICKS) begin
			phase_ticks_q <= pwdata[TICKS_W-1:0];
		end
	end

	// ---------------------------------------------------------------- handshake
	// The result register frees up when empty or when its item is taken.
	assign out_free  = ~out_valid_q | rsp.ready;
	assign s1_go     = s1_valid_q & out_free;
	assign req.ready = ~s1_valid_q | s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req.ready) begin
			s1_valid_q <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			action_s1     <= req.action;
			data_byte_s1  <= req.data_byte;
			master_ack_s1 <= req.master_ack;
			sda_in_s1     <= req.sda_in;
		end
	end

	// ---------------------------------------------------------------- sequencer
	// Phase counter wraps after phase_ticks ticks; zero behaves as one.
	assign phase_more = ({1'b0, phase_count_q} + (TICKS_W+1)'(1)) < {1'b0, phase_ticks_q};

	always_comb begin
		n_phase_count = phase_count_q;
		n_step        = step_q;
		n_bit_count   = bit_count_q;
		n_cmd         = cmd_q;
		n_shift       = shift_q;
		n_ack_choice  = ack_choice_q;
		n_ack_result  = ack_result_q;
		n_read_result = read_result_q;
		n_done        = 1'b0;
		n_rejected    = 1'b0;
		set_drv       = 1'b0;

		if (cmd_q == CMD_IDLE) begin
			// latch a legal command; its first phase drives appear at once
			if (action_s1 inside {CMD_START, CMD_STOP, CMD_WRITE, CMD_READ}) begin
				n_cmd         = action_s1;
				n_phase_count = '0;
				n_step        = '0;
				n_bit_count   = '0;
				if (action_s1 == CMD_WRITE)
					n_shift = data_byte_s1;
				else if (action_s1 == CMD_READ)
					n_shift = '0;
				n_ack_choice  = master_ack_s1;
				set_drv       = 1'b1;
			end
		end else begin
			n_rejected = (action_s1 != CMD_IDLE);
			if (phase_more) begin
				n_phase_count = phase_count_q + TICKS_W'(1);
			end else begin
				n_phase_count = '0;
				if (cmd_q == CMD_WRITE || cmd_q == CMD_READ) begin
					if (step_q == STEP_W'(0)) begin
						n_step  = STEP_W'(1);
						set_drv = 1'b1;
					end else if (step_q == STEP_W'(1)) begin
						if (bit_count_q < BITS_PER_BYTE) begin
							// sample on the last tick of SCL high
							if (cmd_q == CMD_READ) begin
								n_shift = {shift_q[BYTE_W-2:0], sda_in_s1};
								if (bit_count_q == LAST_DATA_BIT)
									n_read_result = n_shift;
							end else begin
								n_shift = {shift_q[BYTE_W-2:0], 1'b0};
							end
							n_bit_count = bit_count_q + BITCNT_W'(1);
							n_step      = STEP_W'(0);
						end else begin
							if (cmd_q == CMD_WRITE)
								n_ack_result = sda_in_s1;
							n_step = STEP_W'(2);
						end
						set_drv = 1'b1;
					end else begin
						n_done = 1'b1;
					end
				end else begin
					if (step_q < STEP_W'(2)) begin
						n_step  = step_q + STEP_W'(1);
						set_drv = 1'b1;
					end else begin
						n_done = 1'b1;
					end
				end
			end
			if (n_done) begin
				n_cmd       = CMD_IDLE;
				n_step      = '0;
				n_bit_count = '0;
			end
		end

		// drives hold after completion until the next command
		n_drive = drive_q;
		if (set_drv)
			n_drive = phase_drive(n_cmd, n_step, n_bit_count, n_shift, n_ack_choice, drive_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_count_q <= '0;
			step_q        <= '0;
			bit_count_q   <= '0;
			cmd_q         <= CMD_IDLE;
			shift_q       <= '0;
			ack_choice_q  <= 1'b0;
			drive_q       <= '0;
			ack_result_q  <= 1'b0;
			read_result_q <= '0;
		end else if (s1_go) begin
			phase_count_q <= n_phase_count;
			step_q        <= n_step;
			bit_count_q   <= n_bit_count;
			cmd_q         <= n_cmd;
			shift_q       <= n_shift;
			ack_choice_q  <= n_ack_choice;
			drive_q       <= n_drive;
			ack_result_q  <= n_ack_result;
			read_result_q <= n_read_result;
		end
	end

	// ---------------------------------------------------------------- result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			busy_q     <= (n_cmd != CMD_IDLE);
			done_q     <= n_done;
			rejected_q <= n_rejected;
		end
	end

	// The line, read and ack fields mirror the state written with this item.
	assign rsp.valid         = out_valid_q;
	assign rsp.scl_drive_low = drive_q.scl_low;
	assign rsp.sda_drive_low = drive_q.sda_low;
	assign rsp.busy_res      = busy_q;
	assign rsp.done_res      = done_q;
	assign rsp.read_data     = read_result_q;
	assign rsp.slave_ack     = ack_result_q;
	assign rsp.rejected      = rejected_q;

endmodule

@@ bench/i2c_master_byte_sequencer_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_sequencer_tb
// Self-checking bench: tick items in, predicted line states out, APB setup.
// ----------------------------------------------------------------------------
//
//  The bench keeps its own copy of the sequencer state and of phase_ticks.
//  Every accepted tick item advances that copy by one tick, and the line
//  state it gives is queued. Every result taken from rsp is checked field by
//  field against the oldest queued state.
//
//  Flow:
//   - reset, read back the phase_ticks reset value
//   - directed table at one tick per phase: ignored codes while idle, all
//     four commands, all-ones and all-zeros bytes, ack and nack from both
//     sides, and every kind of command while busy (rejected)
//   - three random stretches, each at its own phase_ticks and idling mix:
//     mostly start / bytes / stop transactions, the rest lone commands and
//     unused codes on an idle bus
//  phase_ticks is only written once every queued result has been taken.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer_tb;
	import i2cms_pkg::*;

	// unused action codes, ignored on an idle bus and rejected on a busy one
	localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = ACTION_W'(5);
	localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = ACTION_W'(7);

	// steps inside a byte; start and stop simply count phases up to PHASE_LAST
	localparam logic [STEP_W-1:0] SLOT_LOW   = STEP_W'(0);
	localparam logic [STEP_W-1:0] SLOT_HIGH  = STEP_W'(1);
	localparam logic [STEP_W-1:0] BYTE_TAIL  = STEP_W'(2);
	localparam logic [STEP_W-1:0] PHASE_LAST = STEP_W'(2);

	localparam int SLOTS_PER_BYTE = 9;
	localparam int TIMEOUT_UNITS  = 20_000_000;

	typedef struct packed {
		logic              scl_low;
		logic              sda_low;
		logic              busy;
		logic              done;
		logic [BYTE_W-1:0] read_byte;
		logic              slave_ack;
		logic              rejected;
	} tick_result_t;

	localparam tick_result_t RES_QUIET        = '0;
	localparam tick_result_t RES_START_ACCEPT = '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};

	// one directed command: the item itself, the SDA level per bit slot (MSB
	// is the first slot, LSB the ack slot), and the action poked on every
	// busy tick that follows
	typedef struct packed {
		logic [ACTION_W-1:0]       act;
		logic [BYTE_W-1:0]         dat;
		logic                      mack;
		logic [SLOTS_PER_BYTE-1:0] sda_pat;
		logic [ACTION_W-1:0]       poke;
		logic                      typed;
		tick_result_t              want;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic pready;

	i2cms_req_if tick_ch ();
	i2cms_rsp_if line_ch ();

	i2c_master_byte_sequencer u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tick_ch),
		.rsp     (line_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// bench copy of the sequencer
	logic [TICKS_W-1:0]  cfg_phase_ticks;
	logic [TICKS_W-1:0]  seq_count;
	logic [STEP_W-1:0]   seq_step;
	logic [BITCNT_W-1:0] seq_bits;
	logic [ACTION_W-1:0] seq_cmd;
	logic [BYTE_W-1:0]   seq_shift;
	logic                seq_ack_sel;
	logic                seq_scl;
	logic                seq_sda;
	logic                seq_slave_ack;
	logic [BYTE_W-1:0]   seq_read;

	tick_result_t due_line_states[$];
	dir_row_t     dir_rows [16];

	int  mismatch_count;
	int  results_seen;
	int  work_items;
	int  snd_idle_pct;
	int  rcv_idle_pct;
	bit  sda_noise;
	bit  tick_up;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_UNITS);
		$display("** i2c_master_byte_sequencer: FAILED **");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
		mismatch_count++;
	endtask

	// Line drives for the current command, step and bit slot.
	function automatic void set_phase_drives();
		case (seq_cmd)
			CMD_START: begin
				seq_scl = (seq_step >= PHASE_LAST);
				seq_sda = (seq_step >= STEP_W'(1));
			end
			CMD_STOP: begin
				seq_scl = (seq_step == STEP_W'(0));
				seq_sda = (seq_step <= STEP_W'(1));
			end
			CMD_WRITE, CMD_READ: begin
				if (seq_step >= BYTE_TAIL) begin
					// final low phase, SDA let go
					seq_scl = 1'b1;
					seq_sda = 1'b0;
				end else begin
					seq_scl = (seq_step == SLOT_LOW);
					if (seq_bits < BITS_PER_BYTE)
						seq_sda = (seq_cmd == CMD_WRITE) ? ~seq_shift[BYTE_W-1] : 1'b0;
					else
						seq_sda = (seq_cmd == CMD_WRITE) ? 1'b0 : seq_ack_sel;
				end
			end
			default: begin
			end
		endcase
	endfunction

	// Count one tick of the current phase; at the phase end move to the next
	// one, sampling SDA at the end of an SCL-high slot. 1 when the command ends.
	function automatic bit phase_elapsed(input logic sda);
		bit is_byte;
		is_byte = (seq_cmd == CMD_WRITE) || (seq_cmd == CMD_READ);
		if (int'(seq_count) + 1 < int'(cfg_phase_ticks)) begin
			seq_count = seq_count + 1'b1;
			return 1'b0;
		end
		seq_count = '0;
		if (is_byte) begin
			if (seq_step == SLOT_LOW) begin
				seq_step = SLOT_HIGH;
			end else if (seq_step == SLOT_HIGH) begin
				if (seq_bits < BITS_PER_BYTE) begin
					if (seq_cmd == CMD_READ) begin
						seq_shift = {seq_shift[BYTE_W-2:0], sda};
						if (seq_bits == LAST_DATA_BIT)
							seq_read = seq_shift;
					end else begin
						seq_shift = {seq_shift[BYTE_W-2:0], 1'b0};
					end
					seq_bits = seq_bits + 1'b1;
					seq_step = SLOT_LOW;
				end else begin
					if (seq_cmd == CMD_WRITE)
						seq_slave_ack = sda;
					seq_step = BYTE_TAIL;
				end
			end else begin
				return 1'b1;
			end
		end else begin
			if (seq_step < PHASE_LAST)
				seq_step = seq_step + 1'b1;
			else
				return 1'b1;
		end
		set_phase_drives();
		return 1'b0;
	endfunction

	// Advance the bench copy by one tick item and give the line state after it.
	function automatic tick_result_t advance_sequencer(input logic [ACTION_W-1:0] act,
		input logic [BYTE_W-1:0] dat, input logic mack, input logic sda);
		tick_result_t r;
		logic rej;
		logic fin;
		rej = 1'b0;
		fin = 1'b0;
		if (seq_cmd == CMD_IDLE) begin
			// latch a command; its first phase shows on this very tick
			if (act >= CMD_START && act <= CMD_READ) begin
				seq_cmd   = act;
				seq_count = '0;
				seq_step  = '0;
				seq_bits  = '0;
				if (act == CMD_WRITE)
					seq_shift = dat;
				else if (act == CMD_READ)
					seq_shift = '0;
				seq_ack_sel = mack;
				set_phase_drives();
			end
		end else begin
			rej = (act != CMD_IDLE);
			fin = phase_elapsed(sda);
			if (fin) begin
				// drives stay where the last phase left them
				seq_cmd  = CMD_IDLE;
				seq_step = '0;
				seq_bits = '0;
			end
		end
		r = '{seq_scl, seq_sda, seq_cmd != CMD_IDLE, fin, seq_read, seq_slave_ack, rej};
		return r;
	endfunction

	// Offer one tick item, hold it until accepted, then queue its line state.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] dat,
		input logic mack, input logic sda, input bit typed, input tick_result_t typed_res);
		tick_result_t res;
		while ($urandom_range(0, 99) < snd_idle_pct) begin
			if (tick_up) begin
				tick_ch.valid <= 1'b0;
				tick_up = 1'b0;
			end
			@(posedge clk);
		end
		tick_ch.valid      <= 1'b1;
		tick_ch.action     <= act;
		tick_ch.data_byte  <= dat;
		tick_ch.master_ack <= mack;
		tick_ch.sda_in     <= sda;
		tick_up = 1'b1;
		@(posedge clk);
		while (!tick_ch.ready)
			@(posedge clk);
		res = advance_sequencer(act, dat, mack, sda);
		if (res.busy || res.done)
			work_items++;
		due_line_states.push_back(typed ? typed_res : res);
	endtask

	// Issue one command and keep ticking until it completes. SDA follows the
	// slot pattern; busy ticks carry a poke action at the given rate.
	task automatic run_command(input logic [ACTION_W-1:0] act, input logic [BYTE_W-1:0] dat,
		input logic mack, input logic [SLOTS_PER_BYTE-1:0] sda_pat,
		input logic [ACTION_W-1:0] poke, input int poke_pct, input bit typed,
		input tick_result_t typed_res);
		logic [ACTION_W-1:0] a;
		logic s;
		int pat_idx;
		send_item(act, dat, mack, sda_pat[SLOTS_PER_BYTE-1], typed, typed_res);
		while (seq_cmd != CMD_IDLE) begin
			a = CMD_IDLE;
			if ($urandom_range(0, 99) < poke_pct)
				a = (poke != CMD_IDLE) ? poke :
					ACTION_W'($urandom_range(CMD_START, ACT_UNUSED_HI));
			pat_idx = SLOTS_PER_BYTE - 1 - int'(seq_bits);
			if (pat_idx < 0)
				pat_idx = 0;
			s = sda_pat[pat_idx];
			// flips between sample points must not matter
			if (sda_noise && $urandom_range(0, 3) == 0)
				s = ~s;
			send_item(a, BYTE_W'($urandom), 1'($urandom), s, 1'b0, RES_QUIET);
		end
	endtask

	task automatic random_command(input logic [ACTION_W-1:0] act);
		run_command(act, BYTE_W'($urandom), 1'($urandom), SLOTS_PER_BYTE'($urandom),
			CMD_IDLE, 3, 1'b0, RES_QUIET);
	endtask

	// Mostly well-formed transactions with random content; the rest are lone
	// commands in any order and ignored codes on an idle bus.
	task automatic run_random(input int target);
		int start_at;
		int nbytes;
		start_at = work_items;
		while (work_items - start_at < target) begin
			while ($urandom_range(0, 4) == 0) begin
				if ($urandom_range(0, 2) == 0)
					send_item(ACTION_W'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI)),
						BYTE_W'($urandom), 1'($urandom), 1'($urandom), 1'b0, RES_QUIET);
				else
					send_item(CMD_IDLE, BYTE_W'($urandom), 1'($urandom), 1'($urandom),
						1'b0, RES_QUIET);
			end
			if ($urandom_range(0, 99) < 85) begin
				random_command(CMD_START);
				nbytes = $urandom_range(1, 3);
				repeat (nbytes)
					random_command(($urandom_range(0, 9) < 6) ? CMD_WRITE : CMD_READ);
				random_command(CMD_STOP);
			end else begin
				random_command(ACTION_W'($urandom_range(CMD_START, CMD_READ)));
			end
		end
	endtask

	// Drop valid and hold until every queued line state has come back.
	task automatic settle();
		if (tick_up) begin
			tick_ch.valid <= 1'b0;
			tick_up = 1'b0;
		end
		while (due_line_states.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdat,
		output logic [APB_DATA_W-1:0] rdat);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {REG_PHASE_TICKS, 2'b00};
		pwdata  <= wdat;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rdat = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write phase_ticks, mirror it in the bench copy, and read it back.
	task automatic set_phase_ticks(input logic [TICKS_W-1:0] ticks);
		logic [APB_DATA_W-1:0] rd;
		apb_access(1'b1, APB_DATA_W'(ticks), rd);
		cfg_phase_ticks = ticks;
		apb_access(1'b0, '0, rd);
		if (rd !== APB_DATA_W'(ticks))
			report_mismatch("phase_ticks read back", rd, APB_DATA_W'(ticks));
	endtask

	// Take results at random and check each against the oldest queued state.
	always @(posedge clk) begin
		tick_result_t got;
		tick_result_t want;
		if (arst_n) begin
			if (line_ch.valid && line_ch.ready) begin
				got = '{line_ch.scl_drive_low, line_ch.sda_drive_low, line_ch.busy_res,
					line_ch.done_res, line_ch.read_data, line_ch.slave_ack, line_ch.rejected};
				if (due_line_states.size() == 0) begin
					report_mismatch("result with nothing queued", 32'(got), 32'(0));
				end else begin
					want = due_line_states.pop_front();
					if (got.scl_low !== want.scl_low)
						report_mismatch("scl_drive_low", 32'(got.scl_low),
							32'(want.scl_low));
					if (got.sda_low !== want.sda_low)
						report_mismatch("sda_drive_low", 32'(got.sda_low),
							32'(want.sda_low));
					if (got.busy !== want.busy)
						report_mismatch("busy_res", 32'(got.busy), 32'(want.busy));
					if (got.done !== want.done)
						report_mismatch("done_res", 32'(got.done), 32'(want.done));
					if (got.read_byte !== want.read_byte)
						report_mismatch("read_data", 32'(got.read_byte),
							32'(want.read_byte));
					if (got.slave_ack !== want.slave_ack)
						report_mismatch("slave_ack", 32'(got.slave_ack),
							32'(want.slave_ack));
					if (got.rejected !== want.rejected)
						report_mismatch("rejected", 32'(got.rejected),
							32'(want.rejected));
				end
				results_seen++;
			end
			line_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
		end else begin
			line_ch.ready <= 1'b0;
		end
	end

	initial begin
		logic [APB_DATA_W-1:0] rd;
		dir_row_t row;

		// hold every input at a known level through reset
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		tick_ch.valid      = 1'b0;
		tick_ch.action     = CMD_IDLE;
		tick_ch.data_byte  = '0;
		tick_ch.master_ack = 1'b0;
		tick_ch.sda_in     = 1'b0;

		cfg_phase_ticks = PHASE_TICKS_RST;
		seq_count       = '0;
		seq_step        = '0;
		seq_bits        = '0;
		seq_cmd         = CMD_IDLE;
		seq_shift       = '0;
		seq_ack_sel     = 1'b0;
		seq_scl         = 1'b0;
		seq_sda         = 1'b0;
		seq_slave_ack   = 1'b0;
		seq_read        = '0;

		mismatch_count = 0;
		results_seen   = 0;
		work_items     = 0;
		snd_idle_pct   = 28;
		rcv_idle_pct   = 83;
		sda_noise      = 1'b0;
		tick_up        = 1'b0;

		//            action         byte   mack  sda slots  busy poke      typed  expect
		dir_rows = '{
			'{CMD_IDLE,      8'h00, 1'b0, 9'h000, CMD_IDLE,      1'b1, RES_QUIET},
			'{ACT_UNUSED_LO, 8'hFF, 1'b1, 9'h1FF, CMD_IDLE,      1'b1, RES_QUIET},
			'{ACT_UNUSED_HI, 8'hAA, 1'b1, 9'h000, CMD_IDLE,      1'b1, RES_QUIET},
			'{CMD_START,     8'h00, 1'b0, 9'h1FF, CMD_STOP,      1'b1, RES_START_ACCEPT},
			'{CMD_WRITE,     8'hFF, 1'b0, 9'h1FF, CMD_IDLE,      1'b0, RES_QUIET},
			'{CMD_WRITE,     8'h00, 1'b1, 9'h000, ACT_UNUSED_LO, 1'b0, RES_QUIET},
			'{CMD_READ,      8'h00, 1'b1, 9'h1FF, CMD_IDLE,      1'b0, RES_QUIET},
			'{CMD_READ,      8'hFF, 1'b0, 9'h000, ACT_UNUSED_HI, 1'b0, RES_QUIET},
			'{CMD_WRITE,     8'hA5, 1'b0, 9'h0AA, CMD_WRITE,     1'b0, RES_QUIET},
			'{CMD_READ,      8'h3C, 1'b1, 9'h0B5, CMD_READ,      1'b0, RES_QUIET},
			'{CMD_STOP,      8'h00, 1'b0, 9'h000, CMD_START,     1'b0, RES_QUIET},
			'{CMD_STOP,      8'hFF, 1'b1, 9'h1FF, CMD_IDLE,      1'b0, RES_QUIET},
			'{CMD_READ,      8'h00, 1'b0, 9'h155, CMD_STOP,      1'b0, RES_QUIET},
			'{CMD_WRITE,     8'h5A, 1'b1, 9'h0AA, CMD_IDLE,      1'b0, RES_QUIET},
			'{CMD_START,     8'h00, 1'b0, 9'h000, CMD_READ,      1'b0, RES_QUIET},
			'{CMD_IDLE,      8'h00, 1'b0, 9'h000, CMD_IDLE,      1'b0, RES_QUIET}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// phase_ticks must come up at its reset value
		apb_access(1'b0, '0, rd);
		if (rd !== APB_DATA_W'(PHASE_TICKS_RST))
			report_mismatch("phase_ticks after reset", rd, APB_DATA_W'(PHASE_TICKS_RST));

		// directed table, one tick per phase so every row stays short
		set_phase_ticks(TICKS_W'(1));
		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			run_command(row.act, row.dat, row.mack, row.sda_pat, row.poke,
				(row.poke != CMD_IDLE) ? 100 : 0, row.typed, row.want);
		end

		// random stretches: sender slow / receiver slower, then swapped, then flat out
		sda_noise = 1'b1;
		settle();
		set_phase_ticks(TICKS_W'(2));
		run_random(480);

		settle();
		snd_idle_pct = 83;
		rcv_idle_pct = 28;
		set_phase_ticks(TICKS_W'($urandom_range(3, 5)));
		run_random(480);

		settle();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		set_phase_ticks(TICKS_W'(1));
		run_random(480);

		// drain, then keep the clock running so the pipeline can show any stray result
		settle();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0)
			$display("** i2c_master_byte_sequencer: PASSED **");
		else
			$display("** i2c_master_byte_sequencer: FAILED **");
		$finish;
	end

endmodule

@@ sim.f @@
sv/i2cms_pkg.sv
sv/i2cms_if.sv
sv/i2c_master_byte_sequencer.sv
bench/i2c_master_byte_sequencer_tb.sv
